### rtl/keypad_code_lock_defines.svh
// Assertion macros for the keypad code lock RTL.
// Included by the modules that check their own logic; no other dependencies.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef KEYPAD_CODE_LOCK_DEFINES_SVH
`define KEYPAD_CODE_LOCK_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define KCL_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keypad_code_lock: assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define KCL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keypad_code_lock: assertion failed");

`else

`define KCL_ASSERT(label, ante, cons)
`define KCL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/kcl_pkg.sv
// Shared types, key and event codes, and code-value helpers for the keypad code lock.
// No dependencies; used by every module under rtl/.
package kcl_pkg;

  localparam int HISTORY_DIGITS = 8;
  localparam int CODE_DIGITS    = 4;

  localparam logic [3:0]  EMPTY_DIGIT   = 4'd15;
  localparam logic [3:0]  KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0]  KEY_STAR      = 4'd10;
  localparam logic [3:0]  KEY_HASH      = 4'd11;
  localparam logic [3:0]  FULL_COUNT    = 4'd8;
  localparam logic [3:0]  CODE_COUNT    = 4'd4;
  localparam logic [2:0]  STAFF_EXPIRE  = 3'd4;

  localparam logic [13:0] STAFF_CODE_RESET  = 14'd3228;
  localparam logic [13:0] PUBLIC_CODE_RESET = 14'd1111;

  localparam logic [13:0] W1000 = 14'd1000;
  localparam logic [13:0] W100  = 14'd100;
  localparam logic [13:0] W10   = 14'd10;

  typedef enum logic [2:0] {
    EV_DIGIT   = 3'd0,
    EV_STAFF   = 3'd1,
    EV_CANCEL  = 3'd2,
    EV_GRANTED = 3'd3,
    EV_CHANGED = 3'd4,
    EV_ERROR   = 3'd5
  } event_t;

  // One key handed from the input register to the engine.
  typedef struct packed {
    logic       step;
    logic [3:0] key;
  } step_t;

  // One result item.
  typedef struct packed {
    event_t      ev;
    logic        staff;
    logic [3:0]  count;
    logic [15:0] shown;
  } result_t;

  function automatic logic digits_ok(input logic [15:0] nib);
    return (nib[15:12] <= KEY_DIGIT_MAX) && (nib[11:8] <= KEY_DIGIT_MAX) &&
           (nib[7:4] <= KEY_DIGIT_MAX) && (nib[3:0] <= KEY_DIGIT_MAX);
  endfunction

  // Decimal value of four nibbles, most significant first.
  function automatic logic [13:0] code_value(input logic [15:0] nib);
    return 14'(14'(nib[15:12]) * W1000) + 14'(14'(nib[11:8]) * W100) +
           14'(14'(nib[7:4]) * W10) + 14'(nib[3:0]);
  endfunction

endpackage

### rtl/kcl_in_stage.sv
// Input register and flow control of the keypad code lock.
// Depends on kcl_pkg; feeds kcl_engine, backpressured by kcl_out_stage.
module kcl_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [3:0]    in_key_code,
  input  logic          out_free,
  output kcl_pkg::step_t step
);

  logic       valid_r, valid_nxt;
  logic [3:0] key_r;
  logic       key_ok;
  logic       advance;
  logic       take;

  assign key_ok   = key_r <= kcl_pkg::KEY_HASH;
  // unused key codes drain without a result slot
  assign advance  = valid_r && (!key_ok || out_free);
  assign in_stall = valid_r && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      key_r <= in_key_code;
    end
  end

  assign step.step = advance && key_ok;
  assign step.key  = key_r;

endmodule

### rtl/kcl_engine.sv
// Lock state (digit history, staff mode, codes) and per-key next-state logic.
// Depends on kcl_pkg and keypad_code_lock_defines.svh.
`include "keypad_code_lock_defines.svh"

module kcl_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [13:0]      cfg_wr_data,
  input  kcl_pkg::step_t   step,
  output kcl_pkg::result_t res
);

  logic [3:0]  hist_r   [kcl_pkg::HISTORY_DIGITS];
  logic [3:0]  hist_nxt [kcl_pkg::HISTORY_DIGITS];
  logic [3:0]  hist_sh  [kcl_pkg::HISTORY_DIGITS];
  logic [3:0]  count_r, count_nxt;
  logic        staff_r, staff_nxt;
  logic [2:0]  since_r, since_nxt, since_inc;
  logic [13:0] public_r, public_nxt;
  logic [13:0] staff_code_r;
  logic [15:0] cur_nib, sh_nib;
  kcl_pkg::event_t ev;

  always_comb begin
    for (int i = 0; i < kcl_pkg::HISTORY_DIGITS - 1; i++) begin
      hist_sh[i] = hist_r[i + 1];
    end
    hist_sh[kcl_pkg::HISTORY_DIGITS - 1] = step.key;
  end

  assign cur_nib = {hist_r[4], hist_r[5], hist_r[6], hist_r[7]};
  assign sh_nib  = {hist_sh[4], hist_sh[5], hist_sh[6], hist_sh[7]};
  assign since_inc = since_r + 3'd1;

  always_comb begin
    hist_nxt   = hist_r;
    count_nxt  = count_r;
    staff_nxt  = staff_r;
    since_nxt  = since_r;
    public_nxt = public_r;
    ev         = kcl_pkg::EV_DIGIT;
    unique case (step.key) inside
      [4'd0:kcl_pkg::KEY_DIGIT_MAX]: begin
        hist_nxt  = hist_sh;
        count_nxt = (count_r == kcl_pkg::FULL_COUNT) ? count_r : count_r + 4'd1;
        if (staff_r) begin
          if (since_inc > kcl_pkg::STAFF_EXPIRE) begin
            staff_nxt = 1'b0;
            since_nxt = 3'd0;
          end else begin
            since_nxt = since_inc;
          end
        end
        if (kcl_pkg::digits_ok(sh_nib) &&
            kcl_pkg::code_value(sh_nib) == staff_code_r) begin
          staff_nxt = 1'b1;
          since_nxt = 3'd0;
          ev        = kcl_pkg::EV_STAFF;
        end
      end
      kcl_pkg::KEY_STAR: begin
        if (count_r == kcl_pkg::CODE_COUNT) begin
          ev = (kcl_pkg::digits_ok(cur_nib) &&
                kcl_pkg::code_value(cur_nib) == public_r) ?
               kcl_pkg::EV_GRANTED : kcl_pkg::EV_ERROR;
        end else if (count_r == kcl_pkg::FULL_COUNT && staff_r) begin
          public_nxt = kcl_pkg::code_value(cur_nib);
          ev         = kcl_pkg::EV_CHANGED;
        end else begin
          ev = kcl_pkg::EV_ERROR;
        end
        for (int i = 0; i < kcl_pkg::HISTORY_DIGITS; i++) begin
          hist_nxt[i] = kcl_pkg::EMPTY_DIGIT;
        end
        count_nxt = 4'd0;
        staff_nxt = 1'b0;
        since_nxt = 3'd0;
      end
      kcl_pkg::KEY_HASH: begin
        for (int i = 0; i < kcl_pkg::HISTORY_DIGITS; i++) begin
          hist_nxt[i] = kcl_pkg::EMPTY_DIGIT;
        end
        count_nxt = 4'd0;
        staff_nxt = 1'b0;
        since_nxt = 3'd0;
        ev        = kcl_pkg::EV_CANCEL;
      end
      default: begin
        ev = kcl_pkg::EV_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < kcl_pkg::HISTORY_DIGITS; i++) begin
        hist_r[i] <= kcl_pkg::EMPTY_DIGIT;
      end
      count_r      <= 4'd0;
      staff_r      <= 1'b0;
      since_r      <= 3'd0;
      public_r     <= kcl_pkg::PUBLIC_CODE_RESET;
      staff_code_r <= kcl_pkg::STAFF_CODE_RESET;
    end else begin
      if (step.step) begin
        hist_r   <= hist_nxt;
        count_r  <= count_nxt;
        staff_r  <= staff_nxt;
        since_r  <= since_nxt;
        public_r <= public_nxt;
      end
      if (cfg_wr_en) begin
        staff_code_r <= cfg_wr_data;
      end
    end
  end

  assign res.ev    = ev;
  assign res.staff = staff_nxt;
  assign res.count = count_nxt;
  assign res.shown = {hist_nxt[4], hist_nxt[5], hist_nxt[6], hist_nxt[7]};

  `KCL_ASSERT(a_count_range, 1'b1, count_r <= kcl_pkg::FULL_COUNT)
  `KCL_ASSERT(a_staff_has_code, staff_r, count_r >= kcl_pkg::CODE_COUNT)
  `KCL_ASSERT(a_since_idle, !staff_r || since_r > kcl_pkg::STAFF_EXPIRE, since_r == 3'd0)
  `KCL_ASSERT_NEXT(a_cancel_clears, step.step && step.key == kcl_pkg::KEY_HASH,
                   count_r == 4'd0 && !staff_r && hist_r[7] == kcl_pkg::EMPTY_DIGIT)

endmodule

### rtl/kcl_out_stage.sv
// Result register of the keypad code lock; holds an item until it is taken.
// Depends on kcl_pkg; loaded from kcl_engine.
module kcl_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  kcl_pkg::result_t res,
  output logic             out_free,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_event_res,
  output logic             out_staff_active,
  output logic [3:0]       out_digit_count,
  output logic [15:0]      out_shown_digits
);

  logic             valid_r, valid_nxt;
  kcl_pkg::result_t res_r;

  assign out_free  = !valid_r || !out_stall;
  assign valid_nxt = load || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid        = valid_r;
  assign out_event_res    = res_r.ev;
  assign out_staff_active = res_r.staff;
  assign out_digit_count  = res_r.count;
  assign out_shown_digits = res_r.shown;

endmodule

### rtl/keypad_code_lock.sv
// Top level of the keypad code lock: input register, lock engine, result register.
// Depends on kcl_pkg, kcl_in_stage, kcl_engine and kcl_out_stage.
//
//   channel  handshake            payload
//   in       in_valid/in_stall    in_key_code[3:0]
//   out      out_valid/out_stall  out_event_res, out_staff_active, out_digit_count,
//                                 out_shown_digits
//   cfg      cfg_wr_en            cfg_wr_data[13:0] (staff code)
//
// One key per cycle while in_stall is low; a key passes the input register, then the
// result register, before its result is offered, and the result is set by the
// combinational engine update.
// Key codes 12..15 are taken and dropped with no result and no state change.
// A stalled result holds the result register; the input register then fills and
// in_stall rises. Synchronous active-low reset; no clearing pass.
module keypad_code_lock (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [13:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_key_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic        out_staff_active,
  output logic [3:0]  out_digit_count,
  output logic [15:0] out_shown_digits
);

  kcl_pkg::step_t   step;
  kcl_pkg::result_t res;
  logic             out_free;

  kcl_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_key_code (in_key_code),
    .out_free    (out_free),
    .step        (step)
  );

  kcl_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .res         (res)
  );

  kcl_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (step.step),
    .res              (res),
    .out_free         (out_free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_staff_active (out_staff_active),
    .out_digit_count  (out_digit_count),
    .out_shown_digits (out_shown_digits)
  );

endmodule
